FILE: rtl/cpa_pkg.sv
package cpa_pkg;

  localparam int unsigned LW = 11;
  localparam int unsigned OWW = 16;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_FF_RD,
    ST_FF_CHK,
    ST_CP_RD,
    ST_CP_WR,
    ST_ALLOC_WR,
    ST_HSH_RD,
    ST_HSH_WR,
    ST_APPEND,
    ST_PID_RD,
    ST_PID_CHK,
    ST_NB_RD,
    ST_NB_CHK,
    ST_USH_RD,
    ST_USH_WR
  } state_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOCATE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SPACE   = 3'd1;
  localparam logic [2:0] ST_PID_UNKN   = 3'd2;
  localparam logic [2:0] ST_PAGE_RANGE = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic [OWW-1:0] owner;
    logic [LW-1:0]  start;
    logic [LW-1:0]  length;
  } used_t;

  typedef struct packed {
    logic [LW-1:0] start;
    logic [LW-1:0] length;
  } hole_t;

endpackage

FILE: rtl/cpa_ram.sv
module cpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/contiguous_page_allocator.sv
// a request answered at once raises out_valid in the cycle after start; a release takes
// longest, set by the scans and shifts of the used and free tables, each entry
// taking a read state and a check or write state
// throughput: one command at a time; start is taken only while busy is low
// reset: synchronous, active low; after reset or a configuration write, the ST_INIT state
// seeds the free table with a single segment, busy is high during it
// results are strobed on out_valid for one cycle; the receiver cannot stall
module contiguous_page_allocator #(
  parameter int unsigned MAX_PROCS = 32,
  parameter int unsigned MAX_PAGES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_pid,
  input  logic [10:0] in_page_count,
  input  logic [9:0]  in_page_number,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_page_index,
  output logic        out_compacted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int unsigned LW = cpa_pkg::LW;
  localparam int unsigned HCAP = MAX_PROCS + 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 2);
  localparam int unsigned UAW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned HAW = $clog2(HCAP);
  localparam int unsigned TOT_RST = (MAX_PAGES < 1024) ? MAX_PAGES : 1024;

  cpa_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   un_r, un_nxt;
  logic [CW-1:0]   hn_r, hn_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   u_r, u_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [15:0]     pid_r, pid_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [9:0]      pg_r, pg_nxt;
  logic [LW:0]     sum_r, sum_nxt;
  logic [LW-1:0]   s_r, s_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   as_r, as_nxt;
  logic [LW-1:0]   al_r, al_nxt;
  logic            comp_r, comp_nxt;
  logic            right_r, right_nxt;
  logic            ov_r, ov_nxt;
  logic [2:0]      os_r, os_nxt;
  logic [9:0]      oi_r, oi_nxt;
  logic            oc_r, oc_nxt;

  logic            u_we, h_we;
  logic [UAW-1:0]  u_waddr, u_raddr;
  logic [HAW-1:0]  h_waddr, h_raddr;
  cpa_pkg::used_t  u_wdata, u_rdata;
  cpa_pkg::hole_t  h_wdata, h_rdata;

  logic            cfg_fire;
  logic [LW-1:0]   cfg_clamp;
  logic [CW:0]     i_inc;
  logic            hole_fit;
  logic            pid_hit;
  logic            nb_hit;
  logic [LW+1:0]   loc_abs;

  cpa_ram #(.WIDTH($bits(cpa_pkg::used_t)), .DEPTH(MAX_PROCS), .AW(UAW)) u_used (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  cpa_ram #(.WIDTH($bits(cpa_pkg::hole_t)), .DEPTH(HCAP), .AW(HAW)) u_hole (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  assign busy      = (state_r != cpa_pkg::ST_IDLE);
  assign cfg_ready = (state_r == cpa_pkg::ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_page_index = oi_r;
  assign out_compacted  = oc_r;

  assign cfg_clamp = (cfg_data == '0) ? LW'(1) :
                     ((32'(cfg_data) > MAX_PAGES) ? LW'(MAX_PAGES) : cfg_data);
  assign i_inc    = {1'b0, i_r} + (CW+1)'(1);
  assign hole_fit = (h_rdata.length >= cnt_r);
  assign pid_hit  = (u_rdata.owner == pid_r);
  assign nb_hit   = right_r ? (h_rdata.start == s_r + len_r)
                            : ((LW+1)'(h_rdata.start) + (LW+1)'(h_rdata.length)
                               == (LW+1)'(s_r));
  assign loc_abs  = (LW+2)'(u_rdata.start) + (LW+2)'(pg_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpa_pkg::ST_INIT: state_nxt = cpa_pkg::ST_IDLE;
      cpa_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          state_nxt = cpa_pkg::ST_INIT;
        end else if (start) begin
          case (in_command)
            cpa_pkg::CMD_ALLOC: begin
              if (in_page_count != '0 && 32'(un_r) < MAX_PROCS) begin
                state_nxt = cpa_pkg::ST_FF_RD;
              end
            end
            cpa_pkg::CMD_RELEASE, cpa_pkg::CMD_LOCATE: state_nxt = cpa_pkg::ST_PID_RD;
            default: state_nxt = cpa_pkg::ST_IDLE;
          endcase
        end
      end
      cpa_pkg::ST_FF_RD: begin
        if (i_r == hn_r) begin
          state_nxt = (sum_r >= (LW+1)'(cnt_r)) ? cpa_pkg::ST_CP_RD : cpa_pkg::ST_IDLE;
        end else begin
          state_nxt = cpa_pkg::ST_FF_CHK;
        end
      end
      cpa_pkg::ST_FF_CHK:
        state_nxt = hole_fit ? cpa_pkg::ST_ALLOC_WR : cpa_pkg::ST_FF_RD;
      cpa_pkg::ST_CP_RD:
        state_nxt = (i_r == un_r) ? cpa_pkg::ST_ALLOC_WR : cpa_pkg::ST_CP_WR;
      cpa_pkg::ST_CP_WR: state_nxt = cpa_pkg::ST_CP_RD;
      cpa_pkg::ST_ALLOC_WR:
        state_nxt = comp_r ? cpa_pkg::ST_APPEND : cpa_pkg::ST_HSH_RD;
      cpa_pkg::ST_HSH_RD: begin
        if (i_inc >= (CW+1)'(hn_r)) begin
          if (cmd_r == cpa_pkg::CMD_RELEASE && !right_r) begin
            state_nxt = cpa_pkg::ST_NB_RD;
          end else begin
            state_nxt = cpa_pkg::ST_APPEND;
          end
        end else begin
          state_nxt = cpa_pkg::ST_HSH_WR;
        end
      end
      cpa_pkg::ST_HSH_WR: state_nxt = cpa_pkg::ST_HSH_RD;
      cpa_pkg::ST_APPEND:
        state_nxt = (cmd_r == cpa_pkg::CMD_RELEASE) ? cpa_pkg::ST_USH_RD : cpa_pkg::ST_IDLE;
      cpa_pkg::ST_PID_RD:
        state_nxt = (i_r == un_r) ? cpa_pkg::ST_IDLE : cpa_pkg::ST_PID_CHK;
      cpa_pkg::ST_PID_CHK: begin
        if (!pid_hit) begin
          state_nxt = cpa_pkg::ST_PID_RD;
        end else if (cmd_r == cpa_pkg::CMD_RELEASE) begin
          state_nxt = cpa_pkg::ST_NB_RD;
        end else begin
          state_nxt = cpa_pkg::ST_IDLE;
        end
      end
      cpa_pkg::ST_NB_RD: begin
        if (i_r == hn_r) begin
          state_nxt = right_r ? cpa_pkg::ST_APPEND : cpa_pkg::ST_NB_RD;
        end else begin
          state_nxt = cpa_pkg::ST_NB_CHK;
        end
      end
      cpa_pkg::ST_NB_CHK:
        state_nxt = nb_hit ? cpa_pkg::ST_HSH_RD : cpa_pkg::ST_NB_RD;
      cpa_pkg::ST_USH_RD:
        state_nxt = (i_inc >= (CW+1)'(un_r)) ? cpa_pkg::ST_IDLE : cpa_pkg::ST_USH_WR;
      cpa_pkg::ST_USH_WR: state_nxt = cpa_pkg::ST_USH_RD;
      default: state_nxt = cpa_pkg::ST_INIT;
    endcase
  end

  // datapath, memory controls and result word
  always_comb begin
    total_nxt = total_r;
    un_nxt    = un_r;
    hn_nxt    = hn_r;
    i_nxt     = i_r;
    u_nxt     = u_r;
    cmd_nxt   = cmd_r;
    pid_nxt   = pid_r;
    cnt_nxt   = cnt_r;
    pg_nxt    = pg_r;
    sum_nxt   = sum_r;
    s_nxt     = s_r;
    len_nxt   = len_r;
    as_nxt    = as_r;
    al_nxt    = al_r;
    comp_nxt  = comp_r;
    right_nxt = right_r;
    ov_nxt    = 1'b0;
    os_nxt    = os_r;
    oi_nxt    = oi_r;
    oc_nxt    = oc_r;
    u_we      = 1'b0;
    h_we      = 1'b0;
    u_waddr   = i_r[UAW-1:0];
    h_waddr   = i_r[HAW-1:0];
    u_raddr   = i_r[UAW-1:0];
    h_raddr   = i_r[HAW-1:0];
    u_wdata   = u_rdata;
    h_wdata   = h_rdata;
    case (state_r)
      cpa_pkg::ST_INIT: begin
        h_we    = 1'b1;
        h_waddr = '0;
        h_wdata = '{start: '0, length: total_r};
        hn_nxt  = CW'(1);
        un_nxt  = '0;
      end
      cpa_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          total_nxt = cfg_clamp;
        end else if (start) begin
          cmd_nxt   = in_command;
          pid_nxt   = in_pid;
          cnt_nxt   = in_page_count;
          pg_nxt    = in_page_number;
          i_nxt     = '0;
          sum_nxt   = '0;
          comp_nxt  = 1'b0;
          right_nxt = 1'b0;
          oi_nxt    = '0;
          oc_nxt    = 1'b0;
          os_nxt    = cpa_pkg::ST_OK;
          case (in_command)
            cpa_pkg::CMD_ALLOC: begin
              if (in_page_count == '0) begin
                ov_nxt = 1'b1;
                os_nxt = cpa_pkg::ST_NO_SPACE;
              end else if (32'(un_r) >= MAX_PROCS) begin
                ov_nxt = 1'b1;
                os_nxt = cpa_pkg::ST_TABLE_FULL;
              end
            end
            cpa_pkg::CMD_RELEASE, cpa_pkg::CMD_LOCATE: ;
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      cpa_pkg::ST_FF_RD: begin
        if (i_r == hn_r) begin
          if (sum_r >= (LW+1)'(cnt_r)) begin
            i_nxt = '0;
            s_nxt = '0;
          end else begin
            ov_nxt = 1'b1;
            os_nxt = cpa_pkg::ST_NO_SPACE;
          end
        end
      end
      cpa_pkg::ST_FF_CHK: begin
        if (hole_fit) begin
          s_nxt   = h_rdata.start;
          len_nxt = h_rdata.length;
        end else begin
          sum_nxt = sum_r + (LW+1)'(h_rdata.length);
          i_nxt   = i_r + CW'(1);
        end
      end
      cpa_pkg::ST_CP_RD: begin
        if (i_r == un_r) begin
          comp_nxt = 1'b1;
          hn_nxt   = '0;
          len_nxt  = total_r - s_r;
        end
      end
      cpa_pkg::ST_CP_WR: begin
        u_we    = 1'b1;
        u_wdata = '{owner: u_rdata.owner, start: s_r, length: u_rdata.length};
        s_nxt   = s_r + u_rdata.length;
        i_nxt   = i_r + CW'(1);
      end
      cpa_pkg::ST_ALLOC_WR: begin
        u_we    = 1'b1;
        u_waddr = un_r[UAW-1:0];
        u_wdata = '{owner: pid_r, start: s_r, length: cnt_r};
        un_nxt  = un_r + CW'(1);
        as_nxt  = s_r + cnt_r;
        al_nxt  = len_r - cnt_r;
        oi_nxt  = s_r[9:0];
        oc_nxt  = comp_r;
      end
      cpa_pkg::ST_HSH_RD: begin
        h_raddr = i_inc[HAW-1:0];
        if (i_inc >= (CW+1)'(hn_r)) begin
          hn_nxt = hn_r - CW'(1);
          if (cmd_r == cpa_pkg::CMD_RELEASE && !right_r) begin
            right_nxt = 1'b1;
            i_nxt     = '0;
          end
        end
      end
      cpa_pkg::ST_HSH_WR: begin
        h_we  = 1'b1;
        i_nxt = i_r + CW'(1);
      end
      cpa_pkg::ST_APPEND: begin
        if (al_r != '0 && 32'(hn_r) < HCAP) begin
          h_we    = 1'b1;
          h_waddr = hn_r[HAW-1:0];
          h_wdata = '{start: as_r, length: al_r};
          hn_nxt  = hn_r + CW'(1);
        end
        if (cmd_r == cpa_pkg::CMD_RELEASE) begin
          i_nxt = u_r;
        end else begin
          ov_nxt = 1'b1;
        end
      end
      cpa_pkg::ST_PID_RD: begin
        if (i_r == un_r) begin
          ov_nxt = 1'b1;
          os_nxt = cpa_pkg::ST_PID_UNKN;
        end
      end
      cpa_pkg::ST_PID_CHK: begin
        if (!pid_hit) begin
          i_nxt = i_r + CW'(1);
        end else if (cmd_r == cpa_pkg::CMD_RELEASE) begin
          u_nxt   = i_r;
          s_nxt   = u_rdata.start;
          len_nxt = u_rdata.length;
          as_nxt  = u_rdata.start;
          al_nxt  = u_rdata.length;
          i_nxt   = '0;
        end else begin
          ov_nxt = 1'b1;
          if (loc_abs >= (LW+2)'(total_r)) begin
            os_nxt = cpa_pkg::ST_PAGE_RANGE;
          end else begin
            oi_nxt = loc_abs[9:0];
          end
        end
      end
      cpa_pkg::ST_NB_RD: begin
        if (i_r == hn_r && !right_r) begin
          right_nxt = 1'b1;
          i_nxt     = '0;
        end
      end
      cpa_pkg::ST_NB_CHK: begin
        if (nb_hit) begin
          al_nxt = al_r + h_rdata.length;
          if (!right_r) begin
            as_nxt = h_rdata.start;
          end
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      cpa_pkg::ST_USH_RD: begin
        u_raddr = i_inc[UAW-1:0];
        if (i_inc >= (CW+1)'(un_r)) begin
          un_nxt = un_r - CW'(1);
          ov_nxt = 1'b1;
        end
      end
      cpa_pkg::ST_USH_WR: begin
        u_we  = 1'b1;
        i_nxt = i_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpa_pkg::ST_INIT;
      total_r <= LW'(TOT_RST);
      un_r    <= '0;
      hn_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      un_r    <= un_nxt;
      hn_r    <= hn_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    u_r     <= u_nxt;
    cmd_r   <= cmd_nxt;
    pid_r   <= pid_nxt;
    cnt_r   <= cnt_nxt;
    pg_r    <= pg_nxt;
    sum_r   <= sum_nxt;
    s_r     <= s_nxt;
    len_r   <= len_nxt;
    as_r    <= as_nxt;
    al_r    <= al_nxt;
    comp_r  <= comp_nxt;
    right_r <= right_nxt;
    os_r    <= os_nxt;
    oi_r    <= oi_nxt;
    oc_r    <= oc_nxt;
  end

endmodule
